// ----- rtl/slui_pkg.sv -----
// Package for the sorted list intersect/union block.
// Operation codes and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none
package slui_pkg;

  typedef enum logic [1:0] {
    OP_LEFT  = 2'd0,
    OP_RIGHT = 2'd1,
    OP_START = 2'd2
  } op_t;

  localparam int unsigned ID_W = 32;

  typedef struct packed {
    logic step;  // compare heads, advance pointers, emit if due
    logic fin;   // push final beat, clear lists
  } cmd_t;

  typedef struct packed {
    logic out_free;   // output register can take a beat this cycle
    logic term;       // merge finished at current pointers
    logic term_next;  // merge finished after the current step
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/slui_ctrl.sv -----
// Controller for the sorted list intersect/union block.
// Sequences load, read, compare and final beat; uses slui_pkg.
`default_nettype none
module slui_ctrl
  import slui_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_op,
  output logic            in_ready,
  input  sts_t            sts,
  output cmd_t            cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_FIN
  } state_t;

  state_t state;

  logic start_acc;
  assign in_ready  = (state == S_IDLE);
  assign start_acc = in_valid && in_ready && (in_op == OP_START);

  always_comb begin
    cmd = '0;
    case (state)
      S_CMP:   cmd.step = sts.out_free;
      S_FIN:   cmd.fin  = sts.out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start_acc) begin
            state <= sts.term ? S_FIN : S_RD;
          end
        end
        S_RD: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (sts.out_free) begin
            state <= sts.term_next ? S_FIN : S_RD;
          end
        end
        S_FIN: begin
          if (sts.out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/slui_dp.sv -----
// Datapath for the sorted list intersect/union block.
// List memories, counts, merge pointers, pending result and output register; uses slui_pkg.
`default_nettype none
module slui_dp
  import slui_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = 32
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_wen,
  input  wire logic            cfg_wdata,
  input  wire logic            in_valid,
  input  wire logic            in_ready,
  input  wire logic [1:0]      in_op,
  input  wire logic [ID_W-1:0] in_id,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [ID_W-1:0]      out_id,
  output logic                 out_last,
  output logic [1:0]           out_flags
);

  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

  logic [ID_W-1:0] left_mem  [LIST_DEPTH];
  logic [ID_W-1:0] right_mem [LIST_DEPTH];

  logic            merge_mode;
  logic [CW-1:0]   l_cnt, r_cnt, l_ptr, r_ptr;
  logic            dropped;
  logic [ID_W-1:0] a, b;
  logic [ID_W-1:0] pend;
  logic            pend_v;

  logic            acc, ld_l, ld_r, l_room, r_room;
  logic            l_ok, r_ok, l_ok_n, r_ok_n;
  logic            l_adv, r_adv, emit;
  logic [ID_W-1:0] emit_id;
  logic [CW-1:0]   l_ptr_next, r_ptr_next;

  assign acc    = in_valid && in_ready;
  assign ld_l   = acc && (in_op == OP_LEFT);
  assign ld_r   = acc && (in_op == OP_RIGHT);
  assign l_room = (l_cnt < DEPTH_C);
  assign r_room = (r_cnt < DEPTH_C);

  assign l_ok = (l_ptr < l_cnt);
  assign r_ok = (r_ptr < r_cnt);

  always_comb begin
    l_adv   = 1'b0;
    r_adv   = 1'b0;
    emit    = 1'b0;
    emit_id = a;
    if (l_ok && r_ok) begin
      if (a == b) begin
        emit  = 1'b1;
        l_adv = 1'b1;
        r_adv = 1'b1;
      end else if (a < b) begin
        emit  = merge_mode;
        l_adv = 1'b1;
      end else begin
        emit    = merge_mode;
        emit_id = b;
        r_adv   = 1'b1;
      end
    end else if (l_ok) begin
      emit  = merge_mode;
      l_adv = 1'b1;
    end else if (r_ok) begin
      emit    = merge_mode;
      emit_id = b;
      r_adv   = 1'b1;
    end
  end

  assign l_ptr_next = l_ptr + CW'(l_adv);
  assign r_ptr_next = r_ptr + CW'(r_adv);
  assign l_ok_n     = (l_ptr_next < l_cnt);
  assign r_ok_n     = (r_ptr_next < r_cnt);

  assign sts.out_free  = !out_valid || out_ready;
  assign sts.term      = merge_mode ? (!l_ok && !r_ok) : (!l_ok || !r_ok);
  assign sts.term_next = merge_mode ? (!l_ok_n && !r_ok_n) : (!l_ok_n || !r_ok_n);

  // memories: one write port per list, registered read at the merge pointer
  always_ff @(posedge clk) begin
    if (ld_l && l_room) begin
      left_mem[l_cnt[AW-1:0]] <= in_id;
    end
    if (ld_r && r_room) begin
      right_mem[r_cnt[AW-1:0]] <= in_id;
    end
    a <= left_mem[l_ptr[AW-1:0]];
    b <= right_mem[r_ptr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      merge_mode <= 1'b0;
      l_cnt      <= '0;
      r_cnt      <= '0;
      l_ptr      <= '0;
      r_ptr      <= '0;
      dropped    <= 1'b0;
      pend_v     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wen) begin
        merge_mode <= cfg_wdata;
      end
      if (cmd.fin || (cmd.step && emit && pend_v)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (ld_l) begin
        if (l_room) l_cnt <= l_cnt + CW'(1);
        else        dropped <= 1'b1;
      end
      if (ld_r) begin
        if (r_room) r_cnt <= r_cnt + CW'(1);
        else        dropped <= 1'b1;
      end
      if (cmd.step) begin
        l_ptr <= l_ptr_next;
        r_ptr <= r_ptr_next;
        if (emit) begin
          pend   <= emit_id;
          pend_v <= 1'b1;
          if (pend_v) begin
            out_id    <= pend;
            out_last  <= 1'b0;
            out_flags <= {dropped, 1'b0};
          end
        end
      end
      if (cmd.fin) begin
        out_id    <= pend_v ? pend : '0;
        out_last  <= 1'b1;
        out_flags <= {dropped, !pend_v};
        pend_v    <= 1'b0;
        l_cnt     <= '0;
        r_cnt     <= '0;
        l_ptr     <= '0;
        r_ptr     <= '0;
        dropped   <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/sorted_list_intersect_union.sv -----
// Top level of the sorted list intersect/union block.
// Joins slui_ctrl and slui_dp; uses slui_pkg.
//
// Load beats (tuser = left or right) append tdata to a list, one per cycle while
// idle; a load into a full list is dropped and flagged. A start beat merges both
// lists two-pointer style: each compare step is a registered memory read (S_RD)
// followed by a compare (S_CMP); the compare and final-beat states wait while
// the output stalls. One result is held back so the last mark lands on the
// final beat; an empty answer gives a single beat flagged empty. No input is
// taken during a merge.
// merge_mode (cfg port): 0 intersect, 1 union; write it only while idle.
`default_nettype none
module sorted_list_intersect_union
  import slui_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wen,
  input  wire logic        cfg_wdata,      // merge_mode
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // doc_id
  input  wire logic [1:0]  s_axis_tuser,   // operation
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // doc_id_res
  output logic             m_axis_tlast,   // last
  output logic [1:0]       m_axis_tuser    // [0] empty_res, [1] overflow
);

  cmd_t cmd;
  sts_t sts;

  slui_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (s_axis_tuser),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  slui_dp #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (s_axis_tuser),
    .in_id     (s_axis_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_id    (m_axis_tdata),
    .out_last  (m_axis_tlast),
    .out_flags (m_axis_tuser)
  );

endmodule
`default_nettype wire
